>>> src/dsha_pkg.sv
package dsha_pkg;

    // Basic SHA-256 word and container types.
    typedef logic [31:0] word_t;
    typedef logic [7:0][31:0] hash_state_t;
    typedef logic [15:0][31:0] block_t;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W = 64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MIDSTATE_01  = 3'd0,
        REG_MIDSTATE_23  = 3'd1,
        REG_MIDSTATE_45  = 3'd2,
        REG_MIDSTATE_67  = 3'd3,
        REG_TAIL_WORDS_01 = 3'd4,
        REG_TAIL_WORD_2  = 3'd5
    } cfg_reg_t;

    // Padding constants.
    localparam word_t PAD_WORD = 32'h8000_0000;
    localparam word_t LEN_FIRST = 32'h0000_0280;
    localparam word_t LEN_SECOND = 32'h0000_0100;

    localparam int unsigned NUM_ROUNDS = 64;

    localparam word_t ROUND_K [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Standard initial hash value, word 0 in the lowest slot.
    localparam hash_state_t INIT_H = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    function automatic word_t rotr(word_t x, int unsigned n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

    function automatic word_t big_sigma0(word_t x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(word_t x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(word_t x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(word_t x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    // One compression round on the working variables a..h (slots 0..7).
    function automatic hash_state_t sha_round(hash_state_t v, word_t k, word_t w);
        word_t t1;
        word_t t2;
        word_t ch;
        word_t maj;
        hash_state_t r;
        ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
        maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
        t1 = v[7] + big_sigma1(v[4]) + ch + k + w;
        t2 = big_sigma0(v[0]) + maj;
        r[7] = v[6];
        r[6] = v[5];
        r[5] = v[4];
        r[4] = v[3] + t1;
        r[3] = v[2];
        r[2] = v[1];
        r[1] = v[0];
        r[0] = t1 + t2;
        return r;
    endfunction

    // Slides the 16-word schedule window by one word.
    function automatic block_t next_window(block_t w);
        block_t r;
        for (int i = 0; i < 15; i++) begin
            r[i] = w[i+1];
        end
        r[15] = small_sigma1(w[14]) + w[9] + small_sigma0(w[1]) + w[0];
        return r;
    endfunction

endpackage

>>> src/dsha_compress.sv
// One fully unrolled SHA-256 compression: one round per register stage,
// followed by a stage that adds the chaining value back in.
module dsha_compress (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  dsha_pkg::block_t      in_block,
    input  dsha_pkg::word_t       in_nonce,
    input  dsha_pkg::hash_state_t chain_init,
    output logic                  out_valid,
    output dsha_pkg::hash_state_t out_digest,
    output dsha_pkg::word_t       out_nonce
);

    localparam int unsigned ROUNDS = dsha_pkg::NUM_ROUNDS;

    dsha_pkg::hash_state_t v_in [ROUNDS];
    dsha_pkg::block_t      w_in [ROUNDS];
    dsha_pkg::word_t       nonce_in [ROUNDS];
    logic                  valid_in [ROUNDS];

    dsha_pkg::hash_state_t v_next [ROUNDS];
    dsha_pkg::block_t      w_next [ROUNDS];

    dsha_pkg::hash_state_t v_reg [ROUNDS];
    dsha_pkg::block_t      w_reg [ROUNDS];
    dsha_pkg::word_t       nonce_reg [ROUNDS];
    logic                  valid_reg [ROUNDS];

    dsha_pkg::hash_state_t digest_next;
    dsha_pkg::hash_state_t digest_reg;
    dsha_pkg::word_t       done_nonce_reg;
    logic                  done_valid_reg;

    genvar t;
    generate
        for (t = 0; t < ROUNDS; t++) begin : g_round
            // Stage inputs: the port for the first round, the previous stage otherwise.
            if (t == 0) begin : g_first
                assign v_in[t]     = chain_init;
                assign w_in[t]     = in_block;
                assign nonce_in[t] = in_nonce;
                assign valid_in[t] = in_valid;
            end else begin : g_chain
                assign v_in[t]     = v_reg[t-1];
                assign w_in[t]     = w_reg[t-1];
                assign nonce_in[t] = nonce_reg[t-1];
                assign valid_in[t] = valid_reg[t-1];
            end

            // The round uses the oldest word of the schedule window.
            assign v_next[t] = dsha_pkg::sha_round(v_in[t], dsha_pkg::ROUND_K[t], w_in[t][0]);
            assign w_next[t] = dsha_pkg::next_window(w_in[t]);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[t] <= 1'b0;
                end else if (en) begin
                    valid_reg[t] <= valid_in[t];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    v_reg[t]     <= v_next[t];
                    w_reg[t]     <= w_next[t];
                    nonce_reg[t] <= nonce_in[t];
                end
            end
        end
    endgenerate

    // Feed-forward addition of the chaining value.
    always_comb begin
        for (int i = 0; i < 8; i++) begin
            digest_next[i] = v_reg[ROUNDS-1][i] + chain_init[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_valid_reg <= 1'b0;
        end else if (en) begin
            done_valid_reg <= valid_reg[ROUNDS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            digest_reg     <= digest_next;
            done_nonce_reg <= nonce_reg[ROUNDS-1];
        end
    end

    assign out_valid  = done_valid_reg;
    assign out_digest = digest_reg;
    assign out_nonce  = done_nonce_reg;

endmodule

>>> src/double_sha256_header_hash.sv
// Channel   | Handshake          | Payload
// ----------+--------------------+--------------------------------------------
// input     | s_valid / s_ready  | s_nonce
// result    | m_valid / m_ready  | m_hash_word_0..7, m_nonce_echo
// config    | cfg_wr_en          | cfg_index, cfg_wdata (no wait, no read-back)
//
// One nonce is accepted per cycle while s_ready is high; each result then passes through
// the 64 round stages plus one add stage of each of the two compressions and
// the output register. Reset is synchronous and clears only the valid bits and the
// configuration registers. When a result is held at the output, the next result goes
// into a one-entry skid buffer; only while that buffer is full does the whole
// pipeline hold still and s_ready drop, so a stall loses and repeats nothing.
module double_sha256_header_hash (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [dsha_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [dsha_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [31:0]                      s_nonce,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [31:0]                      m_hash_word_0,
    output logic [31:0]                      m_hash_word_1,
    output logic [31:0]                      m_hash_word_2,
    output logic [31:0]                      m_hash_word_3,
    output logic [31:0]                      m_hash_word_4,
    output logic [31:0]                      m_hash_word_5,
    output logic [31:0]                      m_hash_word_6,
    output logic [31:0]                      m_hash_word_7,
    output logic [31:0]                      m_nonce_echo
);

    logic [63:0] midstate_01_reg;
    logic [63:0] midstate_23_reg;
    logic [63:0] midstate_45_reg;
    logic [63:0] midstate_67_reg;
    logic [63:0] tail_words_01_reg;
    logic [31:0] tail_word_2_reg;

    logic                  pipe_en;
    dsha_pkg::hash_state_t midstate;
    dsha_pkg::block_t      first_block;
    dsha_pkg::block_t      second_block;

    logic                  first_valid;
    dsha_pkg::hash_state_t first_digest;
    dsha_pkg::word_t       first_nonce;
    logic                  final_valid;
    dsha_pkg::hash_state_t final_digest;
    dsha_pkg::word_t       final_nonce;

    logic                  out_valid_reg;
    dsha_pkg::hash_state_t out_hash_reg;
    dsha_pkg::word_t       out_nonce_reg;
    logic                  skid_valid_reg;
    dsha_pkg::hash_state_t skid_hash_reg;
    dsha_pkg::word_t       skid_nonce_reg;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            midstate_01_reg   <= '0;
            midstate_23_reg   <= '0;
            midstate_45_reg   <= '0;
            midstate_67_reg   <= '0;
            tail_words_01_reg <= '0;
            tail_word_2_reg   <= '0;
        end else if (cfg_wr_en) begin
            case (dsha_pkg::cfg_reg_t'(cfg_index))
                dsha_pkg::REG_MIDSTATE_01:   midstate_01_reg   <= cfg_wdata;
                dsha_pkg::REG_MIDSTATE_23:   midstate_23_reg   <= cfg_wdata;
                dsha_pkg::REG_MIDSTATE_45:   midstate_45_reg   <= cfg_wdata;
                dsha_pkg::REG_MIDSTATE_67:   midstate_67_reg   <= cfg_wdata;
                dsha_pkg::REG_TAIL_WORDS_01: tail_words_01_reg <= cfg_wdata;
                dsha_pkg::REG_TAIL_WORD_2:   tail_word_2_reg   <= cfg_wdata[31:0];
                default: begin
                end
            endcase
        end
    end

    // The pipeline moves whenever the skid buffer is free.
    assign pipe_en = !skid_valid_reg;
    assign s_ready = pipe_en;

    // Midstate as chaining words, word 0 in the lowest slot.
    assign midstate = {
        midstate_67_reg[31:0], midstate_67_reg[63:32],
        midstate_45_reg[31:0], midstate_45_reg[63:32],
        midstate_23_reg[31:0], midstate_23_reg[63:32],
        midstate_01_reg[31:0], midstate_01_reg[63:32]
    };

    // Padded second block of the header, with the nonce as word 3.
    always_comb begin
        first_block     = '0;
        first_block[0]  = tail_words_01_reg[63:32];
        first_block[1]  = tail_words_01_reg[31:0];
        first_block[2]  = tail_word_2_reg;
        first_block[3]  = s_nonce;
        first_block[4]  = dsha_pkg::PAD_WORD;
        first_block[15] = dsha_pkg::LEN_FIRST;
    end

    // Padded single block holding the first digest.
    always_comb begin
        second_block     = '0;
        for (int i = 0; i < 8; i++) begin
            second_block[i] = first_digest[i];
        end
        second_block[8]  = dsha_pkg::PAD_WORD;
        second_block[15] = dsha_pkg::LEN_SECOND;
    end

    dsha_compress u_first (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (pipe_en),
        .in_valid   (s_valid),
        .in_block   (first_block),
        .in_nonce   (s_nonce),
        .chain_init (midstate),
        .out_valid  (first_valid),
        .out_digest (first_digest),
        .out_nonce  (first_nonce)
    );

    dsha_compress u_second (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (pipe_en),
        .in_valid   (first_valid),
        .in_block   (second_block),
        .in_nonce   (first_nonce),
        .chain_init (dsha_pkg::INIT_H),
        .out_valid  (final_valid),
        .out_digest (final_digest),
        .out_nonce  (final_nonce)
    );

    // Output register with a one-entry skid buffer behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            if (final_valid) begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end else if (m_ready) begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            if (final_valid) begin
                if (!out_valid_reg || m_ready) begin
                    out_hash_reg  <= final_digest;
                    out_nonce_reg <= final_nonce;
                end else begin
                    skid_hash_reg  <= final_digest;
                    skid_nonce_reg <= final_nonce;
                end
            end
        end else if (m_ready) begin
            out_hash_reg  <= skid_hash_reg;
            out_nonce_reg <= skid_nonce_reg;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_hash_word_0 = out_hash_reg[0];
    assign m_hash_word_1 = out_hash_reg[1];
    assign m_hash_word_2 = out_hash_reg[2];
    assign m_hash_word_3 = out_hash_reg[3];
    assign m_hash_word_4 = out_hash_reg[4];
    assign m_hash_word_5 = out_hash_reg[5];
    assign m_hash_word_6 = out_hash_reg[6];
    assign m_hash_word_7 = out_hash_reg[7];
    assign m_nonce_echo  = out_nonce_reg;

endmodule

>>> src/dsha_checker.sv
// Port-level checks on the hash pipeline.
module dsha_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_hash_word_0,
    input logic [31:0] m_hash_word_1,
    input logic [31:0] m_hash_word_2,
    input logic [31:0] m_hash_word_3,
    input logic [31:0] m_hash_word_4,
    input logic [31:0] m_hash_word_5,
    input logic [31:0] m_hash_word_6,
    input logic [31:0] m_hash_word_7,
    input logic [31:0] m_nonce_echo
);

    // A result held at the output stays there until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_nonce_echo)
            && $stable(m_hash_word_0) && $stable(m_hash_word_1)
            && $stable(m_hash_word_2) && $stable(m_hash_word_3)
            && $stable(m_hash_word_4) && $stable(m_hash_word_5)
            && $stable(m_hash_word_6) && $stable(m_hash_word_7))
        else $error("result dropped or changed while stalled");

    // Nothing comes out in the cycle after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // The input side only stalls while a result is waiting at the output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output");

    // A full skid buffer drains as soon as the output is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready && m_ready |=> s_ready)
        else $error("input still stalled after output was taken");

endmodule

bind double_sha256_header_hash dsha_checker u_dsha_checker (.*);
